[rtl/core/bpa_pkg.sv]
package bpa_pkg;

   localparam int NUM_FRAMES_DEF = 1024;
   localparam int NUM_ORDERS_DEF = 7;

   localparam int MARK_W = 4;
   localparam logic [MARK_W-1:0] MARK_BODY = 4'hF;
   localparam logic [MARK_W-1:0] MARK_USED = 4'hE;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_RESERVE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NO_FREE = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] req_order;
      logic [9:0] frame_in;
      logic [4:0] block_count;
   } bpa_req_type;

   typedef struct packed {
      logic [9:0] frame_out;
      logic [2:0] block_order;
      logic [1:0] status;
   } bpa_rsp_type;

   typedef enum logic {
      OP_PUT,
      OP_READ
   } bpa_op_kind_type;

   typedef struct packed {
      logic            start;
      bpa_op_kind_type kind;
   } bpa_op_ctl_type;

   typedef struct packed {
      logic ready;
      logic done;
   } bpa_op_stat_type;

   typedef enum logic [2:0] {
      FS_INIT,
      FS_IDLE,
      FS_RD,
      FS_UNLINK,
      FS_LINK,
      FS_PREV
   } bpa_fs_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_SPLIT,
      S_TAKE,
      S_COUNT,
      S_COUNT_CHK,
      S_FREE_PUT,
      S_MERGE,
      S_MERGE_CHK,
      S_MERGE_FILL,
      S_ISSUE,
      S_WAIT,
      S_FINISH
   } bpa_sq_state_type;

endpackage

[rtl/core/buddy_page_allocator.sv]
// Channel   Ports                               Moves
// request   req_valid, req_stall, req_data     cmd, req_order, frame_in, block_count
// result    rsp_valid, rsp_stall, rsp_data     frame_out, block_order, status
//
// One request at a time; req_stall stays high from acceptance until the result is loaded.
// A store write that puts a frame onto a free list also passes FS_LINK and FS_PREV; a fill
// writes its frames one after another, and a mark read is followed by its check. Allocate
// splits down from the block found at order m; free reads marks to size the block, then
// merges with fills; reserve fills block_count top-order blocks of frames.
// After reset the frame store sweeps every frame of its memories before the first request.
// A stalled result holds in the output register; the next request is still accepted.
module buddy_page_allocator #(
   parameter int NUM_FRAMES = bpa_pkg::NUM_FRAMES_DEF,
   parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bpa_pkg::bpa_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bpa_pkg::bpa_rsp_type rsp_data
);
   import bpa_pkg::*;

   localparam int LW       = $clog2(NUM_FRAMES + 1);
   localparam int OW       = $clog2(NUM_ORDERS);
   localparam int TOP      = NUM_ORDERS - 1;
   localparam int TOP_SIZE = 1 << TOP;
   localparam int CW       = TOP + 1;
   localparam int SW       = ((LW > 5 + TOP) ? LW : 5 + TOP) + 1;
   localparam logic [LW-1:0] NIL   = LW'(NUM_FRAMES);
   localparam logic [OW-1:0] TOP_O = OW'(TOP);
   localparam logic [SW-1:0] NF_S  = SW'(NUM_FRAMES);

   function automatic logic [LW-1:0] clamp_hi(input logic [SW-1:0] x);
      return (x > NF_S) ? NIL : LW'(x);
   endfunction

   bpa_sq_state_type state_ff, state_in, ret_ff, ret_in;
   bpa_req_type      r_ff, r_in;
   bpa_rsp_type      res_ff, res_in, out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   logic [OW-1:0]    o_ff, o_in, v_ff, v_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [LW-1:0]    idx_ff, idx_in, b_ff, b_in;
   logic [1:0]       step_ff, step_in;

   bpa_op_ctl_type   op_ctl;
   bpa_op_stat_type  op_stat;
   bpa_op_kind_type  op_kind_ff, op_kind_in;
   logic [LW-1:0]    op_lo_ff, op_lo_in, op_hi_ff, op_hi_in;
   logic [MARK_W-1:0] op_mark_ff, op_mark_in, rd_mark;
   logic [NUM_ORDERS-1:0][LW-1:0] heads;

   logic             fin_ok, req_ok, count_more, lower_ok, upper_ok;
   logic [LW-1:0]    fin_l, head_o;
   logic [OW-1:0]    req_o;
   logic [SW-1:0]    half, t, pos, cnt_addr, blk_len;
   logic [MARK_W-1:0] v_mark;
   logic [CW-1:0]    i_nx;

   assign fin_ok     = 32'(r_ff.frame_in) < NUM_FRAMES;
   assign fin_l      = LW'(r_ff.frame_in);
   assign req_ok     = 32'(r_ff.req_order) < NUM_ORDERS;
   assign req_o      = OW'(r_ff.req_order);
   assign head_o     = heads[o_ff];
   assign half       = SW'(1) << (o_ff - OW'(1));
   assign blk_len    = SW'(1) << req_o;
   assign t          = SW'(1) << v_ff;
   assign pos        = SW'(idx_ff) & ((t << 1) - SW'(1));
   assign lower_ok   = (pos == '0) && (SW'(idx_ff) + t < NF_S);
   assign upper_ok   = (pos == t);
   assign v_mark     = MARK_W'(v_ff);
   assign cnt_addr   = SW'(fin_l) + SW'(i_ff);
   assign count_more = (32'(i_ff) < TOP_SIZE) && (cnt_addr < NF_S);
   assign i_nx       = i_ff + CW'(1);

   bpa_frame_store #(
      .NUM_FRAMES (NUM_FRAMES),
      .NUM_ORDERS (NUM_ORDERS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .op_ctl  (op_ctl),
      .op_lo   (op_lo_ff),
      .op_hi   (op_hi_ff),
      .op_mark (op_mark_ff),
      .op_stat (op_stat),
      .rd_mark (rd_mark),
      .heads   (heads)
   );

   assign req_stall   = !(state_ff == S_IDLE && op_stat.ready);
   assign op_ctl.start = (state_ff == S_ISSUE);
   assign op_ctl.kind  = op_kind_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_data    = out_ff;

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid && !req_stall) state_in = S_DECODE;
         S_DECODE: begin
            case (r_ff.cmd)
               CMD_ALLOC:   state_in = req_ok ? S_SEARCH : S_FINISH;
               CMD_FREE:    state_in = fin_ok ? S_COUNT : S_FINISH;
               CMD_RESERVE: state_in = fin_ok ? S_ISSUE : S_FINISH;
               default:     state_in = S_FINISH;
            endcase
         end
         S_SEARCH: begin
            if (head_o != NIL) state_in = S_SPLIT;
            else if (o_ff == TOP_O) state_in = S_FINISH;
         end
         S_SPLIT:      state_in = (step_ff == 2'd0 && o_ff == req_o) ? S_TAKE : S_ISSUE;
         S_TAKE:       state_in = (step_ff == 2'd0 && head_o == NIL) ? S_FINISH : S_ISSUE;
         S_COUNT:      state_in = count_more ? S_ISSUE : S_FREE_PUT;
         S_COUNT_CHK:  state_in = (rd_mark == MARK_BODY) ? S_COUNT : S_FREE_PUT;
         S_FREE_PUT:   state_in = S_ISSUE;
         S_MERGE: begin
            state_in = (v_ff != TOP_O && (lower_ok || upper_ok)) ? S_ISSUE : S_FINISH;
         end
         S_MERGE_CHK:  state_in = (rd_mark == v_mark) ? S_ISSUE : S_FINISH;
         S_MERGE_FILL: state_in = S_ISSUE;
         S_ISSUE:      state_in = S_WAIT;
         S_WAIT:       if (op_stat.done) state_in = ret_ff;
         S_FINISH:     if (!out_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin : datapath
      r_in       = r_ff;
      res_in     = res_ff;
      ret_in     = ret_ff;
      o_in       = o_ff;
      v_in       = v_ff;
      i_in       = i_ff;
      idx_in     = idx_ff;
      b_in       = b_ff;
      step_in    = step_ff;
      op_lo_in   = op_lo_ff;
      op_hi_in   = op_hi_ff;
      op_mark_in = op_mark_ff;
      op_kind_in = op_kind_ff;
      out_in     = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) r_in = req_data;
         end
         S_DECODE: begin
            res_in = '{frame_out: '0, block_order: '0, status: ST_INVALID};
            case (r_ff.cmd)
               CMD_ALLOC: o_in = req_o;
               CMD_FREE: begin
                  i_in = CW'(1);
                  v_in = '0;
               end
               CMD_RESERVE: begin
                  if (fin_ok) res_in.status = ST_OK;
                  op_kind_in = OP_PUT;
                  op_lo_in   = fin_l;
                  op_hi_in   = clamp_hi(SW'(fin_l) + (SW'(r_ff.block_count) << TOP));
                  op_mark_in = MARK_USED;
                  ret_in     = S_FINISH;
               end
               default: ;
            endcase
         end
         S_SEARCH: begin
            step_in = 2'd0;
            if (head_o == NIL) begin
               if (o_ff == TOP_O) begin
                  res_in = '{frame_out: '0, block_order: 3'(r_ff.req_order), status: ST_NO_FREE};
               end else begin
                  o_in = o_ff + OW'(1);
               end
            end
         end
         S_SPLIT: begin
            // halve the block at the front of list o: lower half first, upper half last
            op_kind_in = OP_PUT;
            ret_in     = S_SPLIT;
            op_mark_in = MARK_W'(o_ff - OW'(1));
            case (step_ff)
               2'd0: begin
                  b_in     = head_o;
                  op_lo_in = head_o;
                  op_hi_in = head_o + LW'(1);
                  step_in  = 2'd1;
               end
               2'd1: begin
                  op_lo_in   = b_ff + LW'(1);
                  op_hi_in   = clamp_hi(SW'(b_ff) + half);
                  op_mark_in = MARK_BODY;
                  step_in    = 2'd2;
               end
               2'd2: begin
                  op_lo_in = LW'(SW'(b_ff) + half);
                  op_hi_in = LW'(SW'(b_ff) + half + SW'(1));
                  step_in  = 2'd3;
               end
               default: begin
                  op_lo_in   = LW'(SW'(b_ff) + half + SW'(1));
                  op_hi_in   = clamp_hi(SW'(b_ff) + (half << 1));
                  op_mark_in = MARK_BODY;
                  step_in    = 2'd0;
                  o_in       = o_ff - OW'(1);
               end
            endcase
            if (step_ff == 2'd0 && o_ff == req_o) step_in = 2'd0;
         end
         S_TAKE: begin
            op_kind_in = OP_PUT;
            if (step_ff == 2'd0) begin
               if (head_o == NIL) begin
                  res_in = '{frame_out: '0, block_order: 3'(r_ff.req_order), status: ST_NO_FREE};
               end else begin
                  b_in       = head_o;
                  op_lo_in   = head_o;
                  op_hi_in   = head_o + LW'(1);
                  op_mark_in = MARK_USED;
                  ret_in     = S_TAKE;
                  step_in    = 2'd1;
               end
            end else begin
               op_lo_in   = b_ff + LW'(1);
               op_hi_in   = clamp_hi(SW'(b_ff) + blk_len);
               op_mark_in = MARK_BODY;
               ret_in     = S_FINISH;
               res_in = '{frame_out: 10'(b_ff), block_order: 3'(r_ff.req_order), status: ST_OK};
            end
         end
         S_COUNT: begin
            op_kind_in = OP_READ;
            op_lo_in   = LW'(cnt_addr);
            op_hi_in   = LW'(cnt_addr) + LW'(1);
            ret_in     = S_COUNT_CHK;
         end
         S_COUNT_CHK: begin
            if (rd_mark == MARK_BODY) begin
               i_in = i_nx;
               if ((i_nx & i_ff) == '0) v_in = v_ff + OW'(1);
            end
         end
         S_FREE_PUT: begin
            op_kind_in = OP_PUT;
            op_lo_in   = fin_l;
            op_hi_in   = fin_l + LW'(1);
            op_mark_in = v_mark;
            ret_in     = S_MERGE;
            idx_in     = fin_l;
            res_in = '{frame_out: '0, block_order: 3'(v_ff), status: ST_OK};
         end
         S_MERGE: begin
            op_kind_in = OP_READ;
            ret_in     = S_MERGE_CHK;
            if (lower_ok) op_lo_in = LW'(SW'(idx_ff) + t);
            else op_lo_in = LW'(SW'(idx_ff) - t);
            op_hi_in = op_lo_in + LW'(1);
         end
         S_MERGE_CHK: begin
            // buddy is free at the same order: take the lower start and mark one order up
            if (upper_ok) idx_in = LW'(SW'(idx_ff) - t);
            op_kind_in = OP_PUT;
            op_lo_in   = idx_in;
            op_hi_in   = idx_in + LW'(1);
            op_mark_in = MARK_W'(v_ff + OW'(1));
            ret_in     = S_MERGE_FILL;
         end
         S_MERGE_FILL: begin
            op_kind_in = OP_PUT;
            op_lo_in   = idx_ff + LW'(1);
            op_hi_in   = clamp_hi(SW'(idx_ff) + (t << 1));
            op_mark_in = MARK_BODY;
            ret_in     = S_MERGE;
            v_in       = v_ff + OW'(1);
         end
         S_FINISH: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff       <= r_in;
      res_ff     <= res_in;
      ret_ff     <= ret_in;
      o_ff       <= o_in;
      v_ff       <= v_in;
      i_ff       <= i_in;
      idx_ff     <= idx_in;
      b_ff       <= b_in;
      step_ff    <= step_in;
      op_lo_ff   <= op_lo_in;
      op_hi_ff   <= op_hi_in;
      op_mark_ff <= op_mark_in;
      op_kind_ff <= op_kind_in;
      out_ff     <= out_in;
   end

endmodule

[rtl/core/bpa_frame_store.sv]
module bpa_frame_store #(
   parameter int NUM_FRAMES = bpa_pkg::NUM_FRAMES_DEF,
   parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF,
   localparam int LW = $clog2(NUM_FRAMES + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bpa_pkg::bpa_op_ctl_type           op_ctl,
   input  logic [LW-1:0]                     op_lo,
   input  logic [LW-1:0]                     op_hi,
   input  logic [bpa_pkg::MARK_W-1:0]        op_mark,
   output bpa_pkg::bpa_op_stat_type          op_stat,
   output logic [bpa_pkg::MARK_W-1:0]        rd_mark,
   output logic [NUM_ORDERS-1:0][LW-1:0]     heads
);
   import bpa_pkg::*;

   localparam int FW       = $clog2(NUM_FRAMES);
   localparam int OW       = $clog2(NUM_ORDERS);
   localparam int TOP      = NUM_ORDERS - 1;
   localparam int TOP_SIZE = 1 << TOP;
   localparam int NBLK     = NUM_FRAMES / TOP_SIZE;
   localparam logic [LW-1:0] NIL       = LW'(NUM_FRAMES);
   localparam logic [LW-1:0] LAST_HEAD = (NBLK > 0) ? LW'((NBLK - 1) * TOP_SIZE) : LW'(NUM_FRAMES);
   localparam logic [LW-1:0] WHOLE_END = LW'(NBLK * TOP_SIZE);
   localparam logic [LW-1:0] TOP_STEP  = LW'(TOP_SIZE);
   localparam logic [LW-1:0] TOP_MASK  = LW'(TOP_SIZE - 1);
   localparam logic [LW-1:0] LAST_FRM  = LW'(NUM_FRAMES - 1);
   localparam logic [MARK_W-1:0] TOP_MARK = MARK_W'(TOP);

   logic [MARK_W-1:0] mark_mem [NUM_FRAMES];
   logic [LW-1:0]     next_mem [NUM_FRAMES];
   logic [LW-1:0]     prev_mem [NUM_FRAMES];

   bpa_fs_state_type state_ff, state_in;
   bpa_op_kind_type  kind_ff, kind_in;
   logic [LW-1:0]     cur_ff, cur_in, hi_ff, hi_in, h_ff, h_in;
   logic [MARK_W-1:0] mark_ff, mark_in, rmark_ff, rmark_in;
   logic              done_ff, done_in;
   logic [NUM_ORDERS-1:0][LW-1:0] head_ff, head_in;
   logic [MARK_W-1:0] rd_m_ff;
   logic [LW-1:0]     rd_n_ff, rd_p_ff;

   logic              mark_we, next_we, prev_we;
   logic [FW-1:0]     mark_wa, next_wa, prev_wa;
   logic [MARK_W-1:0] mark_wd;
   logic [LW-1:0]     next_wd, prev_wd;

   logic [LW-1:0]     cur_nx;
   logic              last, new_listed, old_listed;
   logic              whole, is_head;
   logic [MARK_W-1:0] init_mark;
   logic [LW-1:0]     init_next, init_prev;

   assign cur_nx     = cur_ff + LW'(1);
   assign last       = (cur_nx >= hi_ff);
   assign new_listed = 32'(mark_ff) < NUM_ORDERS;
   assign old_listed = 32'(rd_m_ff) < NUM_ORDERS;

   // reset image: whole top blocks chained from the highest down, tail used
   assign whole     = cur_ff < WHOLE_END;
   assign is_head   = (cur_ff & TOP_MASK) == '0;
   assign init_mark = whole ? (is_head ? TOP_MARK : MARK_BODY) : MARK_USED;
   assign init_next = (whole && is_head && cur_ff >= TOP_STEP) ? cur_ff - TOP_STEP : NIL;
   assign init_prev = (whole && is_head && cur_ff != LAST_HEAD) ? cur_ff + TOP_STEP : NIL;

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         FS_INIT: begin
            if (cur_ff == LAST_FRM) state_in = FS_IDLE;
         end
         FS_IDLE: begin
            if (op_ctl.start && (op_ctl.kind == OP_READ || op_lo < op_hi)) state_in = FS_RD;
         end
         FS_RD: state_in = FS_UNLINK;
         FS_UNLINK: begin
            if (kind_ff == OP_READ) state_in = FS_IDLE;
            else if (new_listed) state_in = FS_LINK;
            else state_in = last ? FS_IDLE : FS_RD;
         end
         FS_LINK: state_in = FS_PREV;
         FS_PREV: state_in = last ? FS_IDLE : FS_RD;
         default: state_in = FS_IDLE;
      endcase
   end

   always_comb begin : datapath
      cur_in   = cur_ff;
      hi_in    = hi_ff;
      h_in     = h_ff;
      mark_in  = mark_ff;
      kind_in  = kind_ff;
      rmark_in = rmark_ff;
      done_in  = 1'b0;
      head_in  = head_ff;
      mark_we  = 1'b0;
      next_we  = 1'b0;
      prev_we  = 1'b0;
      mark_wa  = cur_ff[FW-1:0];
      next_wa  = cur_ff[FW-1:0];
      prev_wa  = cur_ff[FW-1:0];
      mark_wd  = mark_ff;
      next_wd  = NIL;
      prev_wd  = NIL;
      case (state_ff)
         FS_INIT: begin
            mark_we = 1'b1;
            next_we = 1'b1;
            prev_we = 1'b1;
            mark_wd = init_mark;
            next_wd = init_next;
            prev_wd = init_prev;
            cur_in  = cur_nx;
         end
         FS_IDLE: begin
            if (op_ctl.start) begin
               cur_in  = op_lo;
               hi_in   = op_hi;
               mark_in = op_mark;
               kind_in = op_ctl.kind;
               if (!(op_ctl.kind == OP_READ || op_lo < op_hi)) done_in = 1'b1;
            end
         end
         FS_UNLINK: begin
            if (kind_ff == OP_READ) begin
               rmark_in = rd_m_ff;
               done_in  = 1'b1;
            end else begin
               if (old_listed) begin
                  if (rd_p_ff < NIL) begin
                     next_we = 1'b1;
                     next_wa = rd_p_ff[FW-1:0];
                     next_wd = rd_n_ff;
                  end else begin
                     head_in[rd_m_ff[OW-1:0]] = rd_n_ff;
                  end
                  if (rd_n_ff < NIL) begin
                     prev_we = 1'b1;
                     prev_wa = rd_n_ff[FW-1:0];
                     prev_wd = rd_p_ff;
                  end
               end
               mark_we = 1'b1;
               if (!new_listed) begin
                  cur_in  = cur_nx;
                  done_in = last;
               end
            end
         end
         FS_LINK: begin
            // push on the front of the list
            next_we = 1'b1;
            next_wd = head_ff[mark_ff[OW-1:0]];
            prev_we = 1'b1;
            prev_wd = NIL;
            h_in    = head_ff[mark_ff[OW-1:0]];
            head_in[mark_ff[OW-1:0]] = cur_ff;
         end
         FS_PREV: begin
            if (h_ff != NIL) begin
               prev_we = 1'b1;
               prev_wa = h_ff[FW-1:0];
               prev_wd = cur_ff;
            end
            cur_in  = cur_nx;
            done_in = last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_INIT;
         cur_ff   <= '0;
         done_ff  <= 1'b0;
         for (int k = 0; k < NUM_ORDERS; k++) head_ff[k] <= (k == TOP) ? LAST_HEAD : NIL;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         done_ff  <= done_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      h_ff     <= h_in;
      mark_ff  <= mark_in;
      kind_ff  <= kind_in;
      rmark_ff <= rmark_in;
   end

   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[mark_wa] <= mark_wd;
      if (state_ff == FS_RD) rd_m_ff <= mark_mem[cur_ff[FW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      if (state_ff == FS_RD) rd_n_ff <= next_mem[cur_ff[FW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (state_ff == FS_RD) rd_p_ff <= prev_mem[cur_ff[FW-1:0]];
   end

   assign op_stat.ready = (state_ff != FS_INIT);
   assign op_stat.done  = done_ff;
   assign rd_mark       = rmark_ff;
   assign heads         = head_ff;

endmodule

[rtl/core/bpa_checker.sv]
module bpa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input bpa_pkg::bpa_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input bpa_pkg::bpa_rsp_type rsp_data
);
   import bpa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("undefined status");

   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK && $rose(rsp_valid) |-> rsp_data.frame_out == '0)
      else $error("frame reported on a failed request");

   a_invalid_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_INVALID |-> rsp_data.block_order == '0)
      else $error("order reported on an invalid request");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

[test/tb_buddy_page_allocator.sv]
module tb_buddy_page_allocator;
   import bpa_pkg::*;

   localparam int NF       = NUM_FRAMES_DEF;
   localparam int NO       = NUM_ORDERS_DEF;
   localparam int TOP      = NO - 1;
   localparam int TOP_SZ   = 1 << TOP;
   localparam int NIL      = NF;
   localparam int N_RANDOM = 1150;
   localparam int IDLE_MAX = 20000;
   localparam int HOLD_LEN = 3000;

   // Shadow of the allocator: frame marks, free lists and the results still owed.
   class buddy_shadow;
      int unsigned mark[NF];
      int unsigned nxt[NF];
      int unsigned prv[NF];
      int unsigned head[NO];
      bpa_rsp_type owed[$];
      int errors;

      function new();
         int f;
         errors = 0;
         for (f = 0; f < NF; f++) begin
            mark[f] = MARK_BODY;
            nxt[f]  = NIL;
            prv[f]  = NIL;
         end
         for (f = 0; f < NO; f++) head[f] = NIL;
         for (f = 0; f + TOP_SZ <= NF; f += TOP_SZ) put_mark(f, TOP);
         for (; f < NF; f++) mark[f] = MARK_USED;
      endfunction

      function void unlink(int unsigned f);
         int unsigned o, p, n;
         o = mark[f];
         if (o >= NO) return;
         p = prv[f];
         n = nxt[f];
         if (p < NF) nxt[p] = n;
         else head[o] = n;
         if (n < NF) prv[n] = p;
         nxt[f] = NIL;
         prv[f] = NIL;
      endfunction

      // a free-head mark also pushes the frame onto the front of its list
      function void put_mark(int unsigned f, int unsigned m);
         int unsigned h;
         if (f >= NF) return;
         unlink(f);
         mark[f] = m;
         if (m < NO) begin
            h = head[m];
            nxt[f] = h;
            prv[f] = NIL;
            if (h < NF) prv[h] = f;
            head[m] = f;
         end
      endfunction

      function void fill(int unsigned lo, int unsigned hi, int unsigned m);
         int unsigned f;
         for (f = lo; f < hi && f < NF; f++) put_mark(f, m);
      endfunction

      function void merge_up(int unsigned idx, int unsigned v);
         int unsigned t, pos;
         while (v < TOP) begin
            t   = 1 << v;
            pos = idx & (2 * t - 1);
            if (pos == 0 && idx + t < NF && mark[idx + t] == v) begin
               put_mark(idx, v + 1);
               fill(idx + 1, idx + 2 * t, MARK_BODY);
            end else if (pos == t && mark[idx - t] == v) begin
               idx -= t;
               put_mark(idx, v + 1);
               fill(idx + 1, idx + 2 * t, MARK_BODY);
            end else begin
               return;
            end
            v++;
         end
      endfunction

      function bpa_rsp_type note_request(bpa_req_type r);
         bpa_rsp_type e;
         int unsigned frame, ord, st, o, j, b, half, c, i, req, fin;
         frame = 0;
         ord   = 0;
         st    = ST_INVALID;
         req   = r.req_order;
         fin   = r.frame_in;
         if (r.cmd == CMD_ALLOC) begin
            if (req < NO) begin
               o = req;
               while (o < NO && head[o] >= NF) o++;
               if (o >= NO) begin
                  st  = ST_NO_FREE;
                  ord = req;
               end else begin
                  // split downward; the upper half goes on last and is taken
                  for (j = o; j > req; j--) begin
                     b    = head[j];
                     half = 1 << (j - 1);
                     put_mark(b, j - 1);
                     fill(b + 1, b + half, MARK_BODY);
                     put_mark(b + half, j - 1);
                     fill(b + half + 1, b + 2 * half, MARK_BODY);
                  end
                  frame = head[req];
                  ord   = req;
                  if (frame >= NF) begin
                     frame = 0;
                     st    = ST_NO_FREE;
                  end else begin
                     put_mark(frame, MARK_USED);
                     fill(frame + 1, frame + (1 << req), MARK_BODY);
                     st = ST_OK;
                  end
               end
            end
         end else if (r.cmd == CMD_FREE) begin
            if (fin < NF) begin
               c = 1;
               i = 1;
               while (i < TOP_SZ && fin + i < NF && mark[fin + i] == MARK_BODY) begin
                  c++;
                  i++;
               end
               while (ord < TOP && (c >> (ord + 1)) != 0) ord++;
               put_mark(fin, ord);
               merge_up(fin, ord);
               st = ST_OK;
            end
         end else if (r.cmd == CMD_RESERVE) begin
            if (fin < NF) begin
               fill(fin, fin + r.block_count * TOP_SZ, MARK_USED);
               st = ST_OK;
            end
         end
         e.frame_out   = frame[9:0];
         e.block_order = ord[2:0];
         e.status      = st[1:0];
         owed.push_back(e);
         return e;
      endfunction

      function void check_result(bpa_rsp_type a);
         bpa_rsp_type e;
         if (owed.size() == 0) begin
            $display("%0t: result with nothing owed: frame %0d order %0d status %0d",
                     $time, a.frame_out, a.block_order, a.status);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (a.frame_out !== e.frame_out) begin
            $display("%0t: frame_out expected %0d actual %0d", $time, e.frame_out, a.frame_out);
            errors++;
         end
         if (a.block_order !== e.block_order) begin
            $display("%0t: block_order expected %0d actual %0d",
                     $time, e.block_order, a.block_order);
            errors++;
         end
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   bpa_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   bpa_rsp_type rsp_data;

   buddy_shadow shadow = new();
   int unsigned owned[$];
   int          results_seen = 0;
   int          idle_cycles = 0;
   bit          busy_phase = 1;

   buddy_page_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         shadow.check_result(rsp_data);
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > IDLE_MAX) begin
         $display("tb_buddy_page_allocator failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (!busy_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver: random stalls, one long hold so the block backs up
   initial begin
      int n;
      bit held;
      held = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && results_seen >= 300) begin
            held = 1;
            rsp_stall = 1;
            repeat (HOLD_LEN) @(negedge clock);
            rsp_stall = 0;
         end
         n = pick_gap();
         if (n > 0) begin
            rsp_stall = 1;
            repeat (n) @(negedge clock);
            rsp_stall = 0;
         end
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   task automatic send_request(input bpa_req_type r);
      bpa_rsp_type e;
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid = 0;
         repeat (g) @(negedge clock);
      end
      req_valid = 1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      e = shadow.note_request(r);
      if (r.cmd == CMD_ALLOC && e.status == ST_OK) owned.push_back(e.frame_out);
      @(negedge clock);
   endtask

   function automatic bpa_req_type noise_fields(logic [1:0] cmd);
      bpa_req_type r;
      r.cmd         = cmd;
      r.req_order   = 4'($urandom_range(0, 15));
      r.frame_in    = 10'($urandom_range(0, 1023));
      r.block_count = 5'($urandom_range(0, 16));
      return r;
   endfunction

   task automatic send_alloc(input int ord);
      bpa_req_type r;
      r = noise_fields(CMD_ALLOC);
      r.req_order = 4'(ord);
      send_request(r);
   endtask

   task automatic send_frame_cmd(input logic [1:0] cmd, input int frame, input int cnt);
      bpa_req_type r;
      r = noise_fields(cmd);
      r.frame_in    = 10'(frame);
      r.block_count = 5'(cnt);
      send_request(r);
   endtask

   task automatic send_random();
      int r, k;
      bpa_req_type q;
      r = $urandom_range(0, 99);
      if (owned.size() > 24 && r < 45) r = 60;
      if (r < 45 || (r < 85 && owned.size() == 0)) begin
         k = $urandom_range(0, 99);
         send_alloc(k < 60 ? $urandom_range(0, 2) : (k < 95 ? $urandom_range(3, 6)
                                                         : $urandom_range(7, 15)));
      end else if (r < 85) begin
         k = $urandom_range(0, owned.size() - 1);
         send_frame_cmd(CMD_FREE, owned[k], $urandom_range(0, 16));
         owned.delete(k);
      end else if (r < 92) begin
         send_frame_cmd(CMD_FREE, $urandom_range(0, 1023), $urandom_range(0, 16));
      end else if (r < 96) begin
         send_frame_cmd(CMD_RESERVE, $urandom_range(0, 1023), $urandom_range(0, 1));
      end else begin
         q = noise_fields(2'd3);
         send_request(q);
      end
   endtask

   initial begin
      int i;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      for (i = 0; i < NO; i++) send_alloc(i);
      send_alloc(NO);
      send_alloc(15);
      send_request(noise_fields(2'd3));
      send_frame_cmd(CMD_RESERVE, 5, 0);
      send_frame_cmd(CMD_RESERVE, 1023, 16);
      send_frame_cmd(CMD_FREE, 1023, 0);
      // exhaust the top order to reach the no-free-block case
      for (i = 0; i < 15; i++) send_alloc(TOP);

      for (i = 0; i < N_RANDOM; i++) begin
         if (i % 100 == 0) busy_phase = $urandom_range(0, 3) != 0;
         send_random();
      end
      req_valid = 0;

      while (shadow.owed.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (shadow.errors == 0 && shadow.owed.size() == 0) begin
         $display("tb_buddy_page_allocator passed");
      end else begin
         $display("tb_buddy_page_allocator failed");
      end
      $finish;
   end
endmodule
